/* hdl/rme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and codes for the running median store: request function
// codes, cell array operation codes and the control and flag bundles.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  typedef logic [2:0] rme_op_t;

  localparam rme_op_t OP_HOLD   = 3'd0;
  localparam rme_op_t OP_INS_LO = 3'd1;  // lower half grows, entries <= key shift down
  localparam rme_op_t OP_INS_HI = 3'd2;  // upper half grows, entries > key shift up
  localparam rme_op_t OP_POP_LO = 3'd3;  // lower half closes onto the median cell
  localparam rme_op_t OP_POP_HI = 3'd4;  // upper half closes onto the median cell

  typedef struct packed {
    rme_op_t                   op;
    logic signed [DATA_W-1:0]  key;
  } rme_ctl_t;

  typedef struct packed {
    logic occ;     // cell holds a live entry
    logic brd_lo;  // free cell just below the lower half
    logic brd_hi;  // free cell just above the upper half
    logic lower;   // cell at or below the median cell
    logic upper;   // cell at or above the median cell
  } rme_flags_t;

endpackage
`default_nettype wire

/* hdl/rme_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rme_if
// Valid/ready channels for requests into and medians out of the store.
// ----------------------------------------------------------------------------
interface rme_in_if;
  import rme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface rme_out_if;
  import rme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] median;
  logic [COUNT_W-1:0]       count_after;
  logic                     overflowed;

  modport source (output valid, output median, output count_after, output overflowed,
                  input ready);
  modport sink   (input valid, input median, input count_after, input overflowed,
                  output ready);
endinterface
`default_nettype wire

/* hdl/running_median_extract.sv */
// ----------------------------------------------------------------------------
// running_median_extract
// A pop's median is registered and offered in the cycle after it is taken.
// Throughput: one request per cycle; every cell updates in the same cycle,
// so the rate is set by the output register, which stalls only while full.
// Reset clears both half counts and the overflow flag; cell contents stay
// undefined and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module running_median_extract #(
  parameter int CAPACITY = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rme_in_if.sink     in_ch,
  rme_out_if.source  out_ch
);
  import rme_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]            lcnt_r, lcnt_nxt;
  logic [CW-1:0]            ucnt_r, ucnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] median_r;
  logic [COUNT_W-1:0]       count_r;
  logic                     ovf_out_r;

  logic                     in_acc;
  logic [CW-1:0]            held;
  logic                     full;
  logic                     balanced;
  logic [CW-1:0]            held_dec;
  logic [CW+COUNT_W-1:0]    held_ext;
  logic signed [DATA_W-1:0] med;
  rme_ctl_t                 ctl;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign held        = lcnt_r + ucnt_r;
  assign full        = (held == CW'(CAPACITY));
  assign balanced    = (lcnt_r == ucnt_r);
  assign held_dec    = held - 1'b1;
  assign held_ext    = {{COUNT_W{1'b0}}, held_dec};

  always_comb begin
    ctl.op  = OP_HOLD;
    ctl.key = in_ch.value;
    if (in_acc) begin
      if (in_ch.func == FUNC_INSERT) begin
        if (!full) begin
          ctl.op = balanced ? OP_INS_LO : OP_INS_HI;
        end
      end else if (lcnt_r != '0) begin
        ctl.op = balanced ? OP_POP_HI : OP_POP_LO;
      end
    end
  end

  rme_array #(
    .CAPACITY (CAPACITY)
  ) u_array (
    .clk  (clk),
    .ctl  (ctl),
    .lcnt (lcnt_r),
    .ucnt (ucnt_r),
    .med  (med)
  );

  always_comb begin
    lcnt_nxt      = lcnt_r;
    ucnt_nxt      = ucnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_acc && in_ch.func == FUNC_INSERT && full) begin
      ovf_nxt = 1'b1;
    end
    unique case (ctl.op)
      OP_INS_LO: lcnt_nxt = lcnt_r + 1'b1;
      OP_INS_HI: ucnt_nxt = ucnt_r + 1'b1;
      OP_POP_LO: begin
        lcnt_nxt      = lcnt_r - 1'b1;
        out_valid_nxt = 1'b1;
      end
      OP_POP_HI: begin
        ucnt_nxt      = ucnt_r - 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r      <= '0;
      ucnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lcnt_r      <= lcnt_nxt;
      ucnt_r      <= ucnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_POP_LO || ctl.op == OP_POP_HI) begin
      median_r  <= med;
      count_r   <= held_ext[COUNT_W-1:0];
      ovf_out_r <= ovf_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.median      = median_r;
  assign out_ch.count_after = count_r;
  assign out_ch.overflowed  = ovf_out_r;

  // lower half holds the median: same size as the upper half or one more
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (lcnt_r == ucnt_r) || (lcnt_r == ucnt_r + 1'b1))
    else $error("half counts out of balance");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_POP && lcnt_r != '0) |=> out_valid_r)
    else $error("pop on non-empty store gave no result");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_INSERT && full) |=> (ovf_r && $stable(held)))
    else $error("insert into full store not dropped");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && !out_valid_r) |=> !out_valid_r)
    else $error("result without a request");

endmodule
`default_nettype wire

/* hdl/rme_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rme_cell
// One slot of the sorted array. Compares its entry with the broadcast key
// and takes a neighbor's entry, the key, or keeps its own.
// ----------------------------------------------------------------------------
module rme_cell (
  input  wire logic                             clk,
  input  wire rme_pkg::rme_ctl_t                ctl,
  input  wire rme_pkg::rme_flags_t              flags,
  input  wire logic signed [rme_pkg::DATA_W-1:0] left_val,
  input  wire logic                             left_gt,
  input  wire logic signed [rme_pkg::DATA_W-1:0] right_val,
  input  wire logic                             right_le,
  output logic signed [rme_pkg::DATA_W-1:0]     val,
  output logic                                  le,
  output logic                                  gt
);
  import rme_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  assign val = val_r;
  assign le  = flags.occ && (val_r <= ctl.key);
  assign gt  = flags.occ && (val_r >  ctl.key);

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      OP_INS_LO: begin
        if (right_le) begin
          val_nxt = right_val;
        end else if (le || flags.brd_lo) begin
          val_nxt = ctl.key;
        end
      end
      OP_INS_HI: begin
        if (left_gt) begin
          val_nxt = left_val;
        end else if (gt || flags.brd_hi) begin
          val_nxt = ctl.key;
        end
      end
      OP_POP_LO: begin
        if (flags.lower) begin
          val_nxt = left_val;
        end
      end
      OP_POP_HI: begin
        if (flags.upper) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

/* hdl/rme_array.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rme_array
// Chain of cells holding the multiset in order, lower median pinned at the
// median cell. Derives each cell's occupancy and boundary flags from the
// half counts.
// ----------------------------------------------------------------------------
module rme_array #(
  parameter  int CAPACITY = 1024,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk,
  input  wire rme_pkg::rme_ctl_t                 ctl,
  input  wire logic [CW-1:0]                     lcnt,
  input  wire logic [CW-1:0]                     ucnt,
  output logic signed [rme_pkg::DATA_W-1:0]      med
);
  import rme_pkg::*;

  localparam int MID = (CAPACITY + 1) / 2 - 1;

  logic signed [DATA_W-1:0] val [CAPACITY];
  logic                     le  [CAPACITY];
  logic                     gt  [CAPACITY];

  assign med = val[MID];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rme_flags_t               flags;
    logic signed [DATA_W-1:0] left_val;
    logic                     left_gt;
    logic signed [DATA_W-1:0] right_val;
    logic                     right_le;

    if (i <= MID) begin : g_lo
      localparam logic [CW-1:0] DL = CW'(MID - i);
      assign flags.occ    = (lcnt > DL);
      assign flags.brd_lo = (lcnt == DL);
      assign flags.brd_hi = 1'b0;
      assign flags.lower  = 1'b1;
      assign flags.upper  = (i == MID);
    end else begin : g_hi
      localparam logic [CW-1:0] DU = CW'(i - MID - 1);
      assign flags.occ    = (ucnt > DU);
      assign flags.brd_lo = 1'b0;
      assign flags.brd_hi = (ucnt == DU);
      assign flags.lower  = 1'b0;
      assign flags.upper  = 1'b1;
    end

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_left
      assign left_val = val[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
      assign right_le  = 1'b0;
    end else begin : g_right
      assign right_val = val[i+1];
      assign right_le  = le[i+1];
    end

    rme_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .flags     (flags),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .right_le  (right_le),
      .val       (val[i]),
      .le        (le[i]),
      .gt        (gt[i])
    );
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for running_median_extract. Requests are checked against
// a sorted-queue model of the store: a short table of edge cases first, then
// random insert/pop traffic, a long output stall, and a fill past capacity to
// exercise the sticky overflow flag.
// ----------------------------------------------------------------------------
module tb;
  import rme_pkg::*;

  localparam int STORE_DEPTH = 1024;

  typedef struct packed {
    logic signed [DATA_W-1:0] median;
    logic [COUNT_W-1:0]       count_after;
    logic                     overflowed;
  } median_rec_t;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    median_rec_t              want;
  } stim_row_t;

  localparam int NUM_ROWS = 22;

  // typed rows carry the median read straight off the sequence above them
  localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    '{FUNC_POP,    32'sh00000000, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'sh7FFFFFFF, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b1, '{32'sh7FFFFFFF, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'sh80000000, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'sh7FFFFFFF, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'shFFFFFFFF, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'sh00000000, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b1, '{32'shFFFFFFFF, 11'd3, 1'b0}},
    '{FUNC_INSERT, 32'shFFFFFFFF, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'shFFFFFFFF, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b1, '{32'shFFFFFFFF, 11'd4, 1'b0}},
    '{FUNC_POP,    32'sh12345678, 1'b1, '{32'shFFFFFFFF, 11'd3, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b1, '{32'sh00000000, 11'd2, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b1, '{32'sh80000000, 11'd1, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b1, '{32'sh7FFFFFFF, 11'd0, 1'b0}},
    '{FUNC_POP,    32'shFFFFFFFF, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'sh55555555, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'shAAAAAAAA, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_INSERT, 32'sh00000001, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b0, '{32'sh00000000, 11'd0, 1'b0}},
    '{FUNC_POP,    32'sh00000000, 1'b0, '{32'sh00000000, 11'd0, 1'b0}}
  };

  logic clk;
  logic rst_n;

  rme_in_if  in_ch ();
  rme_out_if out_ch ();

  running_median_extract #(.CAPACITY(STORE_DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [DATA_W-1:0] sorted_vals [$];
  logic                     store_overflowed;
  median_rec_t              pending_medians [$];
  int                       mismatch_count;
  int                       burst_left;
  int                       hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // model of the store: one sorted queue, new values placed after equal ones
  function automatic bit apply_to_store(input logic f, input logic signed [DATA_W-1:0] v,
                                        output median_rec_t res);
    int pos;
    res = '0;
    if (f == FUNC_INSERT) begin
      if (sorted_vals.size() >= STORE_DEPTH) begin
        store_overflowed = 1'b1;
        return 1'b0;
      end
      pos = 0;
      while (pos < sorted_vals.size() && sorted_vals[pos] <= v) pos++;
      sorted_vals.insert(pos, v);
      return 1'b0;
    end
    if (sorted_vals.size() == 0) return 1'b0;
    pos = (sorted_vals.size() - 1) / 2;
    res.median = sorted_vals[pos];
    sorted_vals.delete(pos);
    res.count_after = COUNT_W'(sorted_vals.size());
    res.overflowed  = store_overflowed;
    return 1'b1;
  endfunction

  function automatic void enqueue_median(input median_rec_t m);
    pending_medians.insert(pending_medians.size(), m);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      4, 5:    return $signed($urandom_range(0, 16)) - 8;
      6: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFFFFFF;
          1:       return 32'sh80000000;
          2:       return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      7:       return 32'sh7FFFFFFF - $signed($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic f, input logic signed [DATA_W-1:0] v,
                              input bit typed, input median_rec_t want);
    median_rec_t got;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        in_ch.func  <= 1'($urandom);
        in_ch.value <= $urandom;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (apply_to_store(f, v, got)) enqueue_median(typed ? want : got);
  endtask

  task automatic mixed_round(input int n_items, input int pop_pct);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < pop_pct)
        send_request(FUNC_POP, $urandom, 1'b0, '0);
      else
        send_request(FUNC_INSERT, rand_value(), 1'b0, '0);
    end
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int          hold_left;
    int          mode;
    int          mode_left;
    int          ready_pct;
    int          step;
    logic [15:0] pattern;
    hold_left = 0;
    mode_left = 0;
    step = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
          ready_pct = $urandom_range(10, 90);
          pattern   = 16'($urandom);
        end
        mode_left--;
        step++;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= pattern[step % 16];
          default: out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    median_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_medians.size() == 0) begin
        $display("%0t: unexpected median %0d count %0d overflow %0b", $time,
                 out_ch.median, out_ch.count_after, out_ch.overflowed);
        mismatch_count++;
      end else begin
        want = pending_medians.pop_front();
        if (out_ch.median !== want.median) begin
          $display("%0t: median expected %0d actual %0d", $time, want.median,
                   out_ch.median);
          mismatch_count++;
        end
        if (out_ch.count_after !== want.count_after) begin
          $display("%0t: count_after expected %0d actual %0d", $time, want.count_after,
                   out_ch.count_after);
          mismatch_count++;
        end
        if (out_ch.overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b", $time, want.overflowed,
                   out_ch.overflowed);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    mismatch_count   = 0;
    burst_left       = 0;
    hold_req         = 0;
    store_overflowed = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= FUNC_INSERT;
    in_ch.value <= '0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++)
      send_request(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                   DIRECTED_ROWS[r].want);

    for (int r = 0; r < 10; r++) begin
      if (r == 3) hold_req = 400;
      mixed_round(90, (r == 3) ? 50 : $urandom_range(20, 60));
    end

    // fill to capacity, then push past it
    while (sorted_vals.size() < STORE_DEPTH)
      send_request(FUNC_INSERT, rand_value(), 1'b0, '0);
    for (int k = 0; k < 12; k++)
      send_request(FUNC_INSERT, rand_value(), 1'b0, '0);
    for (int k = 0; k < 60; k++)
      send_request(FUNC_POP, $urandom, 1'b0, '0);
    mixed_round(120, 50);
    in_ch.valid <= 1'b0;

    while (pending_medians.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
hdl/rme_pkg.sv
hdl/rme_if.sv
hdl/rme_cell.sv
hdl/rme_array.sv
hdl/running_median_extract.sv
tb/tb.sv
